// File: rtl/core/qspc_pkg.sv
// Shared codes and sizes for the quadrature speed PID controller.
package qspc_pkg;

    localparam int CFG_DATA_W  = 21;
    localparam int CFG_INDEX_W = 2;
    localparam int TARGET_W    = 21;
    localparam int GAIN_W      = 16;
    localparam int WORD_W      = 32;
    localparam int DIVIDEND_W  = 41;
    localparam int DIV_CNT_W   = 6;
    localparam int PROD_W      = GAIN_W + WORD_W + 1;
    localparam int ACC_W       = PROD_W + 2;
    localparam int QUOT_W      = ACC_W - 8;

    typedef enum logic [1:0] {
        OP_ENCODER = 2'd0,
        OP_TICK    = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_TARGET = 2'd0,
        CFG_GAIN_P = 2'd1,
        CFG_GAIN_I = 2'd2,
        CFG_GAIN_D = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        DIR_STOP     = 2'd0,
        DIR_FORWARD  = 2'd1,
        DIR_BACKWARD = 2'd2
    } dir_t;

    localparam logic [1:0] STEP_UP   = 2'd1;
    localparam logic [1:0] STEP_DOWN = 2'd3;

    localparam logic [7:0] DUTY_MAX = 8'd255;

endpackage

// File: rtl/core/quadrature_speed_pid_controller.sv
// Quadrature encoder counter with speed estimate and PID duty output, one unit.
//
// Each item produces one result. An encoder sample, a position clear or an unused
// op is accepted and then loads the output register. A control tick is accepted,
// then passes the scale by 1000 (S_SCALE1, S_SCALE2), the bit-serial restoring
// divider that divides the scaled count change by the elapsed milliseconds, and
// then the speed sign and saturation, the error, the integral, the three Q8.8
// gain products, which share one 16 by 33 bit multiplier in turn, the final sum,
// the clamp and the output register. A tick with zero elapsed time skips the
// scale and the divider and keeps the old speed. The result waits in S_FINISH
// while the output register holds a result not yet taken. The block takes one item
// at a time and accepts the next item while the previous result still waits at the
// output register.
module quadrature_speed_pid_controller (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           op,
    input  logic                                 pin_a,
    input  logic                                 pin_b,
    input  logic [31:0]                          now_ms,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [31:0]                   position,
    output logic signed [31:0]                   speed,
    output logic [7:0]                           pwm_duty,
    output logic [1:0]                           direction,
    input  logic                                 cfg_we,
    input  logic [qspc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [qspc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCALE1,
        S_SCALE2,
        S_DIV,
        S_SPEED,
        S_ERR,
        S_SUM,
        S_MUL_P,
        S_MUL_I,
        S_MUL_D,
        S_ACC,
        S_QUANT,
        S_FINISH
    } state_t;

    localparam int DW = qspc_pkg::DIVIDEND_W;
    localparam int WW = qspc_pkg::WORD_W;

    state_t state_reg;

    logic signed [qspc_pkg::TARGET_W-1:0] target_reg;
    logic signed [qspc_pkg::GAIN_W-1:0]   gain_p_reg;
    logic signed [qspc_pkg::GAIN_W-1:0]   gain_i_reg;
    logic signed [qspc_pkg::GAIN_W-1:0]   gain_d_reg;

    logic [WW-1:0]          count_reg;
    logic                   prev_a_reg;
    logic                   prev_b_reg;
    logic [WW-1:0]          last_tick_reg;
    logic [WW-1:0]          last_count_reg;
    logic signed [WW-1:0]   speed_est_reg;
    logic signed [WW-1:0]   error_sum_reg;
    logic signed [WW-1:0]   last_error_reg;
    logic [7:0]             duty_reg;

    logic [WW-1:0]                        dt_reg;
    logic [WW-1:0]                        mag_reg;
    logic                                 neg_reg;
    logic [DW-1:0]                        work_reg;
    logic [WW-1:0]                        rem_reg;
    logic [qspc_pkg::DIV_CNT_W-1:0]       cnt_reg;
    logic signed [WW-1:0]                 err_reg;
    logic signed [WW:0]                   deriv_reg;
    logic signed [qspc_pkg::PROD_W-1:0]   prod_reg;
    logic signed [qspc_pkg::ACC_W-1:0]    acc_reg;

    logic                   out_valid_reg;
    logic signed [WW-1:0]   position_reg;
    logic signed [WW-1:0]   speed_reg;
    logic [7:0]             pwm_duty_reg;
    logic [1:0]             direction_reg;

    function automatic logic [1:0] phase_of(input logic a, input logic b);
        logic [1:0] p;
        if (a)
        begin
            p = b ? 2'd2 : 2'd1;
        end
        else
        begin
            p = b ? 2'd3 : 2'd0;
        end
        return p;
    endfunction

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31])
        begin
            r = v[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    logic [1:0]                           enc_step;
    logic [WW-1:0]                        dp;
    logic [DW-1:0]                        mag_wide;
    logic [WW:0]                          rem_shift;
    logic                                 rem_ge;
    logic [WW-1:0]                        rem_next;
    logic signed [WW:0]                   err_diff;
    logic signed [WW:0]                   sum_wide;
    logic signed [qspc_pkg::GAIN_W-1:0]   mul_a;
    logic signed [WW:0]                   mul_b;
    logic signed [qspc_pkg::PROD_W-1:0]   mul_prod;
    logic signed [qspc_pkg::ACC_W-1:0]    acc_adj;
    logic signed [qspc_pkg::QUOT_W-1:0]   quot;
    logic signed [qspc_pkg::QUOT_W-1:0]   quot_abs;
    logic [7:0]                           duty_next;
    logic [1:0]                           dir_next;

    always_comb
    begin
        enc_step  = phase_of(pin_a, pin_b) - phase_of(prev_a_reg, prev_b_reg);
        dp        = count_reg - last_count_reg;
        mag_wide  = DW'(mag_reg);
        rem_shift = {rem_reg, work_reg[DW-1]};
        rem_ge    = rem_shift >= {1'b0, dt_reg};
        rem_next  = rem_ge ? WW'(rem_shift - {1'b0, dt_reg}) : rem_shift[WW-1:0];
        err_diff  = (WW+1)'(target_reg) - (WW+1)'(speed_est_reg);
        sum_wide  = (WW+1)'(error_sum_reg) + (WW+1)'(err_reg);

        unique case (state_reg)
            S_MUL_P:
            begin
                mul_a = gain_p_reg;
                mul_b = (WW+1)'(err_reg);
            end
            S_MUL_I:
            begin
                mul_a = gain_i_reg;
                mul_b = (WW+1)'(error_sum_reg);
            end
            default:
            begin
                mul_a = gain_d_reg;
                mul_b = deriv_reg;
            end
        endcase
        mul_prod = mul_a * mul_b;

        acc_adj  = acc_reg + (acc_reg[qspc_pkg::ACC_W-1] ?
                              qspc_pkg::ACC_W'(255) : qspc_pkg::ACC_W'(0));
        quot     = acc_adj[qspc_pkg::ACC_W-1:8];
        quot_abs = quot[qspc_pkg::QUOT_W-1] ? -quot : quot;
        if (quot > qspc_pkg::QUOT_W'(255) || quot < -qspc_pkg::QUOT_W'(255))
        begin
            duty_next = qspc_pkg::DUTY_MAX;
        end
        else
        begin
            duty_next = quot_abs[7:0];
        end

        if (target_reg == '0)
        begin
            dir_next = qspc_pkg::DIR_STOP;
        end
        else if (target_reg[qspc_pkg::TARGET_W-1])
        begin
            dir_next = qspc_pkg::DIR_BACKWARD;
        end
        else
        begin
            dir_next = qspc_pkg::DIR_FORWARD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            gain_p_reg <= '0;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                qspc_pkg::CFG_TARGET: target_reg <= $signed(cfg_data);
                qspc_pkg::CFG_GAIN_P: gain_p_reg <= $signed(cfg_data[qspc_pkg::GAIN_W-1:0]);
                qspc_pkg::CFG_GAIN_I: gain_i_reg <= $signed(cfg_data[qspc_pkg::GAIN_W-1:0]);
                qspc_pkg::CFG_GAIN_D: gain_d_reg <= $signed(cfg_data[qspc_pkg::GAIN_W-1:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            prev_a_reg     <= 1'b0;
            prev_b_reg     <= 1'b0;
            last_tick_reg  <= '0;
            last_count_reg <= '0;
            speed_est_reg  <= '0;
            error_sum_reg  <= '0;
            last_error_reg <= '0;
            duty_reg       <= '0;
            dt_reg         <= '0;
            mag_reg        <= '0;
            neg_reg        <= 1'b0;
            work_reg       <= '0;
            rem_reg        <= '0;
            cnt_reg        <= '0;
            err_reg        <= '0;
            deriv_reg      <= '0;
            prod_reg       <= '0;
            acc_reg        <= '0;
            out_valid_reg  <= 1'b0;
            position_reg   <= '0;
            speed_reg      <= '0;
            pwm_duty_reg   <= '0;
            direction_reg  <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != S_FINISH)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_FINISH;
                        unique case (op)
                            qspc_pkg::OP_ENCODER:
                            begin
                                if (enc_step == qspc_pkg::STEP_UP)
                                begin
                                    count_reg <= count_reg + 32'd1;
                                end
                                else if (enc_step == qspc_pkg::STEP_DOWN)
                                begin
                                    count_reg <= count_reg - 32'd1;
                                end
                                prev_a_reg <= pin_a;
                                prev_b_reg <= pin_b;
                            end
                            qspc_pkg::OP_TICK:
                            begin
                                dt_reg         <= now_ms - last_tick_reg;
                                last_tick_reg  <= now_ms;
                                last_count_reg <= count_reg;
                                neg_reg        <= dp[WW-1];
                                mag_reg        <= dp[WW-1] ? (~dp + 32'd1) : dp;
                                state_reg      <= (now_ms == last_tick_reg) ? S_ERR : S_SCALE1;
                            end
                            qspc_pkg::OP_CLEAR:
                            begin
                                count_reg <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCALE1:
                begin
                    work_reg  <= (mag_wide << 10) - (mag_wide << 4);
                    state_reg <= S_SCALE2;
                end
                S_SCALE2:
                begin
                    work_reg  <= work_reg - (mag_wide << 3);
                    rem_reg   <= '0;
                    cnt_reg   <= qspc_pkg::DIV_CNT_W'(DW - 1);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg  <= rem_next;
                    work_reg <= {work_reg[DW-2:0], rem_ge};
                    cnt_reg  <= cnt_reg - qspc_pkg::DIV_CNT_W'(1);
                    if (cnt_reg == '0)
                    begin
                        state_reg <= S_SPEED;
                    end
                end
                S_SPEED:
                begin
                    if (!neg_reg)
                    begin
                        speed_est_reg <= (work_reg > DW'(32'h7FFFFFFF)) ?
                                         32'sh7FFFFFFF : $signed(work_reg[WW-1:0]);
                    end
                    else
                    begin
                        speed_est_reg <= (work_reg > DW'(32'h80000000)) ?
                                         32'sh80000000 :
                                         $signed(~work_reg[WW-1:0] + 32'd1);
                    end
                    state_reg <= S_ERR;
                end
                S_ERR:
                begin
                    err_reg   <= sat33(err_diff);
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    error_sum_reg  <= sat33(sum_wide);
                    deriv_reg      <= (WW+1)'(err_reg) - (WW+1)'(last_error_reg);
                    last_error_reg <= err_reg;
                    state_reg      <= S_MUL_P;
                end
                S_MUL_P:
                begin
                    prod_reg  <= mul_prod;
                    acc_reg   <= '0;
                    state_reg <= S_MUL_I;
                end
                S_MUL_I:
                begin
                    prod_reg  <= mul_prod;
                    acc_reg   <= acc_reg + qspc_pkg::ACC_W'(prod_reg);
                    state_reg <= S_MUL_D;
                end
                S_MUL_D:
                begin
                    prod_reg  <= mul_prod;
                    acc_reg   <= acc_reg + qspc_pkg::ACC_W'(prod_reg);
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    acc_reg   <= acc_reg + qspc_pkg::ACC_W'(prod_reg);
                    state_reg <= S_QUANT;
                end
                S_QUANT:
                begin
                    duty_reg  <= duty_next;
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        position_reg  <= $signed(count_reg);
                        speed_reg     <= speed_est_reg;
                        pwm_duty_reg  <= duty_reg;
                        direction_reg <= dir_next;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign position  = position_reg;
    assign speed     = speed_reg;
    assign pwm_duty  = pwm_duty_reg;
    assign direction = direction_reg;

endmodule
